FILE: rtl/core/fgs_pkg.sv
package fgs_pkg;

    // field widths
    localparam int BW   = 15;   // breakpoint width
    localparam int GW   = 16;   // gain register width
    localparam int XW   = 16;   // input sample width
    localparam int OW   = 18;   // result width
    localparam int FRAC = 16;   // weight fraction bits
    localparam int WW   = FRAC + 1;      // weight width, 1.0 included
    localparam int PW   = 2 * WW;        // weight product width
    localparam int TW   = PW + 3;        // rule-weighted sum width
    localparam int MW   = TW + GW;       // scaled sum width
    localparam int SW   = 3;             // set index width
    localparam int CIW  = 3;             // config index width

    // divider stages (must divide FRAC)
    localparam int DIV_STAGES = 4;

    // register reset values
    localparam logic [BW-1:0] ERR_BREAK_1_RST  = 15'd50;
    localparam logic [BW-1:0] ERR_BREAK_2_RST  = 15'd100;
    localparam logic [BW-1:0] ERR_BREAK_3_RST  = 15'd150;
    localparam logic [BW-1:0] RATE_BREAK_0_RST = 15'd110;
    localparam logic [BW-1:0] RATE_BREAK_1_RST = 15'd150;
    localparam logic [BW-1:0] RATE_BREAK_2_RST = 15'd250;
    localparam logic [BW-1:0] RATE_BREAK_3_RST = 15'd350;
    localparam logic [GW-1:0] OUTPUT_GAIN_RST  = 16'd256;

    localparam logic [OW-1:0] GAIN_MAX  = 18'h3FFFF;
    localparam logic [WW-1:0] HALF      = 17'd32768;
    localparam logic [SW-1:0] SET_ZERO  = 3'd3;
    localparam logic [SW-1:0] SET_NB    = 3'd0;
    localparam logic [SW-1:0] SET_PB    = 3'd6;

    // config register indexes
    typedef enum logic [CIW-1:0] {
        CFG_ERR_BREAK_1  = 3'd0,
        CFG_ERR_BREAK_2  = 3'd1,
        CFG_ERR_BREAK_3  = 3'd2,
        CFG_RATE_BREAK_0 = 3'd3,
        CFG_RATE_BREAK_1 = 3'd4,
        CFG_RATE_BREAK_2 = 3'd5,
        CFG_RATE_BREAK_3 = 3'd6,
        CFG_OUTPUT_GAIN  = 3'd7
    } cfg_idx_t;

    // fuzzifier result for one value
    typedef struct packed {
        logic [BW-1:0] rem;      // first partial remainder
        logic [BW-1:0] span;     // divisor
        logic          q0;       // leading quotient bit
        logic [SW-1:0] set_in;
        logic [SW-1:0] set_out;
        logic          special;  // both weights one half
    } fuzz_t;

    // sideband that travels beside the dividers
    typedef struct packed {
        logic [SW-1:0] e_in;
        logic [SW-1:0] e_out;
        logic [SW-1:0] r_in;
        logic [SW-1:0] r_out;
        logic          e_sp;
        logic          r_sp;
        logic          bad;
    } side_t;

    // rule table, row is error set, column is rate set
    localparam logic [2:0] RULES [7][7] = '{
        '{3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd4, 3'd3, 3'd0, 3'd3, 3'd4, 3'd4},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd4},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd4},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd4}
    };

    function automatic logic [2:0] rule_at(input logic [SW-1:0] row,
                                           input logic [SW-1:0] col);
        logic [2:0] val;
        val = 3'd0;
        if (row < 3'd7 && col < 3'd7)
        begin
            val = RULES[row][col];
        end
        return val;
    endfunction

endpackage

FILE: rtl/core/fgs_if.sv
interface fgs_sample_if;
    logic                             valid;
    logic                             ready;
    logic signed [fgs_pkg::XW-1:0]    error_in;
    logic signed [fgs_pkg::XW-1:0]    rate_in;

    modport source (output valid, output error_in, output rate_in, input ready);
    modport sink   (input valid, input error_in, input rate_in, output ready);
endinterface

interface fgs_result_if;
    logic                      valid;
    logic                      ready;
    logic [fgs_pkg::OW-1:0]    gain_out;

    modport source (output valid, output gain_out, input ready);
    modport sink   (input valid, input gain_out, output ready);
endinterface

FILE: rtl/core/fuzzy_gain_scheduler_unit.sv
// fuzzy gain scheduler: error and error-rate item in, one Q10.8 gain item out
//
// sample channel: error_in and rate_in, signed 16 bit; result channel: gain_out,
// unsigned Q10.8, 18 bit, saturating. both use valid/ready, an item moves when
// both are high. config port: cfg_we, cfg_index, cfg_data; write only while
// the block is idle. breakpoints that are not strictly increasing give 0.
//
// one item is accepted every cycle while the pipeline is not backed up by a
// stall at the result side; the rate is set by the pipelined weight dividers
// (four divider stages by default), which resolve 16 / DIV_STAGES quotient
// bits per stage.
//
// each stage holds its own valid bit and advances when empty or when the next
// stage moves, so a stall at the result side only backs up full stages and
// the block keeps taking items until the pipeline is full. nothing is lost
// or repeated. reset clears the valid bits and loads the register defaults.
module fuzzy_gain_scheduler_unit #(
    parameter int DIV_STAGES = fgs_pkg::DIV_STAGES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fgs_sample_if.sink                  sample,
    fgs_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [fgs_pkg::CIW-1:0]     cfg_index,
    input  logic [fgs_pkg::GW-1:0]      cfg_data
);

    localparam int NST = DIV_STAGES + 4;

    logic [fgs_pkg::BW-1:0] err_break_1_reg;
    logic [fgs_pkg::BW-1:0] err_break_2_reg;
    logic [fgs_pkg::BW-1:0] err_break_3_reg;
    logic [fgs_pkg::BW-1:0] rate_break_0_reg;
    logic [fgs_pkg::BW-1:0] rate_break_1_reg;
    logic [fgs_pkg::BW-1:0] rate_break_2_reg;
    logic [fgs_pkg::BW-1:0] rate_break_3_reg;
    logic [fgs_pkg::GW-1:0] output_gain_reg;

    logic [NST-1:0]         v_reg;
    logic [NST-1:0]         v_next;
    logic [NST-1:0]         en;

    fgs_pkg::fuzz_t         fz_e;
    fgs_pkg::fuzz_t         fz_r;
    fgs_pkg::fuzz_t         fz_e_reg;
    fgs_pkg::fuzz_t         fz_r_reg;
    fgs_pkg::side_t         sb_next;
    fgs_pkg::side_t         sb_reg [DIV_STAGES+1];
    logic                   bad;

    logic [fgs_pkg::WW-1:0] q_e;
    logic [fgs_pkg::WW-1:0] q_r;
    logic                   rnz_e;
    logic                   rnz_r;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_break_1_reg  <= fgs_pkg::ERR_BREAK_1_RST;
            err_break_2_reg  <= fgs_pkg::ERR_BREAK_2_RST;
            err_break_3_reg  <= fgs_pkg::ERR_BREAK_3_RST;
            rate_break_0_reg <= fgs_pkg::RATE_BREAK_0_RST;
            rate_break_1_reg <= fgs_pkg::RATE_BREAK_1_RST;
            rate_break_2_reg <= fgs_pkg::RATE_BREAK_2_RST;
            rate_break_3_reg <= fgs_pkg::RATE_BREAK_3_RST;
            output_gain_reg  <= fgs_pkg::OUTPUT_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (fgs_pkg::cfg_idx_t'(cfg_index))
                fgs_pkg::CFG_ERR_BREAK_1:  err_break_1_reg  <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_ERR_BREAK_2:  err_break_2_reg  <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_ERR_BREAK_3:  err_break_3_reg  <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_RATE_BREAK_0: rate_break_0_reg <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_RATE_BREAK_1: rate_break_1_reg <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_RATE_BREAK_2: rate_break_2_reg <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_RATE_BREAK_3: rate_break_3_reg <= cfg_data[fgs_pkg::BW-1:0];
                fgs_pkg::CFG_OUTPUT_GAIN:  output_gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables, a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || result.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        v_next[0] = en[0] ? sample.valid : v_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample.ready = en[0];
    assign result.valid = v_reg[NST-1];

    // fuzzification of both inputs
    fgs_fuzz u_fuzz_e (
        .x   (sample.error_in),
        .bp0 ('0),
        .bp1 (err_break_1_reg),
        .bp2 (err_break_2_reg),
        .bp3 (err_break_3_reg),
        .fz  (fz_e)
    );

    fgs_fuzz u_fuzz_r (
        .x   (sample.rate_in),
        .bp0 (rate_break_0_reg),
        .bp1 (rate_break_1_reg),
        .bp2 (rate_break_2_reg),
        .bp3 (rate_break_3_reg),
        .fz  (fz_r)
    );

    // breakpoint ordering check
    assign bad = !((err_break_1_reg != '0) &&
                   (err_break_1_reg < err_break_2_reg) &&
                   (err_break_2_reg < err_break_3_reg) &&
                   (rate_break_0_reg < rate_break_1_reg) &&
                   (rate_break_1_reg < rate_break_2_reg) &&
                   (rate_break_2_reg < rate_break_3_reg));

    always_comb
    begin
        sb_next.e_in  = fz_e.set_in;
        sb_next.e_out = fz_e.set_out;
        sb_next.r_in  = fz_r.set_in;
        sb_next.r_out = fz_r.set_out;
        sb_next.e_sp  = fz_e.special;
        sb_next.r_sp  = fz_r.special;
        sb_next.bad   = bad;
    end

    // first stage register and sideband line beside the dividers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fz_e_reg  <= fz_e;
            fz_r_reg  <= fz_r;
            sb_reg[0] <= sb_next;
        end
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            if (en[i])
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    // weight dividers
    fgs_div #(.NSTAGE(DIV_STAGES)) u_div_e (
        .clk     (clk),
        .en      (en[DIV_STAGES:1]),
        .rem_in  (fz_e_reg.rem),
        .span_in (fz_e_reg.span),
        .q0_in   (fz_e_reg.q0),
        .q_out   (q_e),
        .rnz_out (rnz_e)
    );

    fgs_div #(.NSTAGE(DIV_STAGES)) u_div_r (
        .clk     (clk),
        .en      (en[DIV_STAGES:1]),
        .rem_in  (fz_r_reg.rem),
        .span_in (fz_r_reg.span),
        .q0_in   (fz_r_reg.q0),
        .q_out   (q_r),
        .rnz_out (rnz_r)
    );

    // rule evaluation and scaling
    fgs_defuzz u_defuzz (
        .clk      (clk),
        .en       (en[NST-1:DIV_STAGES+1]),
        .q_e      (q_e),
        .rnz_e    (rnz_e),
        .q_r      (q_r),
        .rnz_r    (rnz_r),
        .sb       (sb_reg[DIV_STAGES]),
        .gain     (output_gain_reg),
        .gain_out (result.gain_out)
    );

endmodule

FILE: rtl/core/fgs_fuzz.sv
module fgs_fuzz (
    input  logic [fgs_pkg::XW-1:0] x,
    input  logic [fgs_pkg::BW-1:0] bp0,
    input  logic [fgs_pkg::BW-1:0] bp1,
    input  logic [fgs_pkg::BW-1:0] bp2,
    input  logic [fgs_pkg::BW-1:0] bp3,
    output fgs_pkg::fuzz_t         fz
);

    logic                     neg;
    logic [fgs_pkg::XW:0]     mag;
    logic                     zone_zero;
    logic                     zone_sat;
    logic [1:0]               k;
    logic [fgs_pkg::BW-1:0]   lo;
    logic [fgs_pkg::BW-1:0]   hi;
    logic [fgs_pkg::BW-1:0]   num;

    // magnitude, most negative value gives 32768
    assign neg = x[fgs_pkg::XW-1];
    assign mag = neg ? (17'd65536 - 17'(x)) : 17'(x);

    assign zone_zero = mag <= 17'(bp0);
    assign zone_sat  = mag > 17'(bp3);

    // segment select
    always_comb
    begin
        if (mag <= 17'(bp1))
        begin
            k  = 2'd0;
            lo = bp0;
            hi = bp1;
        end
        else if (mag <= 17'(bp2))
        begin
            k  = 2'd1;
            lo = bp1;
            hi = bp2;
        end
        else
        begin
            k  = 2'd2;
            lo = bp2;
            hi = bp3;
        end
    end

    assign num = fgs_pkg::BW'(mag - 17'(lo));

    // first quotient bit: outside the zero and saturation zones num never exceeds the span
    always_comb
    begin
        fz.span    = hi - lo;
        fz.q0      = (num == fz.span);
        fz.rem     = fz.q0 ? '0 : num;
        fz.special = zone_zero || zone_sat;
        if (zone_zero)
        begin
            fz.set_in  = fgs_pkg::SET_ZERO;
            fz.set_out = fgs_pkg::SET_ZERO;
        end
        else if (zone_sat)
        begin
            fz.set_in  = neg ? fgs_pkg::SET_NB : fgs_pkg::SET_PB;
            fz.set_out = neg ? fgs_pkg::SET_NB : fgs_pkg::SET_PB;
        end
        else if (neg)
        begin
            fz.set_in  = 3'd3 - 3'(k);
            fz.set_out = 3'd2 - 3'(k);
        end
        else
        begin
            fz.set_in  = 3'd3 + 3'(k);
            fz.set_out = 3'd4 + 3'(k);
        end
    end

endmodule

FILE: rtl/core/fgs_div.sv
module fgs_div #(
    parameter int NSTAGE = fgs_pkg::DIV_STAGES
) (
    input  logic                     clk,
    input  logic [NSTAGE-1:0]        en,
    input  logic [fgs_pkg::BW-1:0]   rem_in,
    input  logic [fgs_pkg::BW-1:0]   span_in,
    input  logic                     q0_in,
    output logic [fgs_pkg::WW-1:0]   q_out,
    output logic                     rnz_out
);

    localparam int STEPS = fgs_pkg::FRAC / NSTAGE;

    logic [fgs_pkg::BW-1:0] rem_reg  [NSTAGE];
    logic [fgs_pkg::BW-1:0] span_reg [NSTAGE];
    logic [fgs_pkg::WW-1:0] q_reg    [NSTAGE];
    logic [fgs_pkg::BW-1:0] rem_next [NSTAGE];
    logic [fgs_pkg::WW-1:0] q_next   [NSTAGE];

    genvar g;
    generate
        for (g = 0; g < NSTAGE; g++)
        begin : g_stage
            logic [fgs_pkg::BW-1:0] r_src;
            logic [fgs_pkg::BW-1:0] s_src;
            logic [fgs_pkg::WW-1:0] q_src;

            if (g == 0)
            begin : g_first
                assign r_src = rem_in;
                assign s_src = span_in;
                assign q_src = fgs_pkg::WW'(q0_in);
            end
            else
            begin : g_next
                assign r_src = rem_reg[g-1];
                assign s_src = span_reg[g-1];
                assign q_src = q_reg[g-1];
            end

            // restoring steps, one quotient bit each
            always_comb
            begin
                logic [fgs_pkg::BW:0]   t;
                logic [fgs_pkg::BW-1:0] r;
                logic [fgs_pkg::WW-1:0] q;
                r = r_src;
                q = q_src;
                for (int i = 0; i < STEPS; i++)
                begin
                    t = {r, 1'b0};
                    if (t >= {1'b0, s_src})
                    begin
                        r = fgs_pkg::BW'(t - {1'b0, s_src});
                        q = {q[fgs_pkg::WW-2:0], 1'b1};
                    end
                    else
                    begin
                        r = t[fgs_pkg::BW-1:0];
                        q = {q[fgs_pkg::WW-2:0], 1'b0};
                    end
                end
                rem_next[g] = r;
                q_next[g]   = q;
            end

            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    rem_reg[g]  <= rem_next[g];
                    span_reg[g] <= s_src;
                    q_reg[g]    <= q_next[g];
                end
            end
        end
    endgenerate

    assign q_out   = q_reg[NSTAGE-1];
    assign rnz_out = (rem_reg[NSTAGE-1] != '0);

endmodule

FILE: rtl/core/fgs_defuzz.sv
module fgs_defuzz (
    input  logic                     clk,
    input  logic [2:0]               en,
    input  logic [fgs_pkg::WW-1:0]   q_e,
    input  logic                     rnz_e,
    input  logic [fgs_pkg::WW-1:0]   q_r,
    input  logic                     rnz_r,
    input  fgs_pkg::side_t           sb,
    input  logic [fgs_pkg::GW-1:0]   gain,
    output logic [fgs_pkg::OW-1:0]   gain_out
);

    logic [fgs_pkg::WW-1:0] ew [2];
    logic [fgs_pkg::WW-1:0] rw [2];
    logic [fgs_pkg::SW-1:0] es [2];
    logic [fgs_pkg::SW-1:0] rs [2];

    logic [fgs_pkg::PW-1:0] p_reg    [2][2];
    logic [2:0]             rule_reg [2][2];
    logic                   bad1_reg;
    logic [fgs_pkg::TW-1:0] tot_reg;
    logic [fgs_pkg::TW-1:0] tot_next;
    logic                   bad2_reg;
    logic [fgs_pkg::OW-1:0] gain_out_reg;
    logic [fgs_pkg::OW-1:0] gain_out_next;
    logic [fgs_pkg::MW-1:0] scaled;
    logic [fgs_pkg::MW-33:0] shifted;

    // weights: outer is the quotient, inner its truncated complement
    always_comb
    begin
        ew[1] = sb.e_sp ? fgs_pkg::HALF : q_e;
        ew[0] = sb.e_sp ? fgs_pkg::HALF
                        : fgs_pkg::WW'(18'd65536 - 18'(q_e) - 18'(rnz_e));
        rw[1] = sb.r_sp ? fgs_pkg::HALF : q_r;
        rw[0] = sb.r_sp ? fgs_pkg::HALF
                        : fgs_pkg::WW'(18'd65536 - 18'(q_r) - 18'(rnz_r));
        es[0] = sb.e_in;
        es[1] = sb.e_out;
        rs[0] = sb.r_in;
        rs[1] = sb.r_out;
    end

    // weight products and rule lookup
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    p_reg[i][j]    <= fgs_pkg::PW'(ew[i]) * fgs_pkg::PW'(rw[j]);
                    rule_reg[i][j] <= fgs_pkg::rule_at(es[i], rs[j]);
                end
            end
            bad1_reg <= sb.bad;
        end
    end

    // rule-weighted sum
    always_comb
    begin
        tot_next = '0;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                tot_next = tot_next + fgs_pkg::TW'(rule_reg[i][j]) *
                                      fgs_pkg::TW'(p_reg[i][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tot_reg  <= tot_next;
            bad2_reg <= bad1_reg;
        end
    end

    // gain scaling, truncation and saturation; bad breakpoints give zero
    assign scaled  = fgs_pkg::MW'(tot_reg) * fgs_pkg::MW'(gain);
    assign shifted = scaled[fgs_pkg::MW-1:32];

    always_comb
    begin
        if (bad2_reg)
        begin
            gain_out_next = '0;
        end
        else if (shifted > (fgs_pkg::MW-32)'(fgs_pkg::GAIN_MAX))
        begin
            gain_out_next = fgs_pkg::GAIN_MAX;
        end
        else
        begin
            gain_out_next = shifted[fgs_pkg::OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            gain_out_reg <= gain_out_next;
        end
    end

    assign gain_out = gain_out_reg;

endmodule

FILE: rtl/core/fgs_checker.sv
module fgs_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_ready,
    input  logic                    r_valid,
    input  logic                    r_ready,
    input  logic [fgs_pkg::OW-1:0]  r_gain
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> $stable(r_gain))
        else $error("result changed while stalled");

    // an empty output stage never blocks the sample side
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> s_ready)
        else $error("sample blocked with empty output");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !r_valid)
        else $error("result valid after reset");

endmodule

bind fuzzy_gain_scheduler_unit fgs_checker u_fgs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_gain  (result.gain_out)
);
